[rtl/pod_pkg.sv]
// ----------------------------------------------------------------------------
// pod_pkg
// Shared request modes, result status codes and the decision record that
// the update logic hands to the page ownership directory top level.
// ----------------------------------------------------------------------------
package pod_pkg;

    // Request mode as carried on the mode port
    typedef enum logic [1:0] {
        REQ_SHARE   = 2'd0,
        REQ_OWN     = 2'd1,
        REQ_LEASE   = 2'd2,
        REQ_ILLEGAL = 2'd3
    } mode_t;

    // Result status codes
    localparam logic [1:0] STATUS_GRANTED = 2'd0;
    localparam logic [1:0] STATUS_OWNER   = 2'd1;
    localparam logic [1:0] STATUS_BAD     = 2'd2;

    // Outcome of one request, from the update logic to the control
    typedef struct packed {
        logic bad;          // malformed request, nothing changes
        logic already;      // requester already holds the page or lease
        logic page_grant;   // page entry is rewritten, page transfer counted
        logic write_grant;  // granted write, invalidations counted
        logic lease_grant;  // lease moves, lease transfer counted
    } pod_decision_t;

endpackage : pod_pkg

[rtl/page_ownership_directory_unit.sv]
// ----------------------------------------------------------------------------
// page_ownership_directory_unit
// Coherence directory with write-invalidate: page owner and reader mask per
// page in a synchronous memory, one lease holder and three counters.
// ----------------------------------------------------------------------------
// Result: a request accepted in the idle state has its directory entry read,
//   and its result is loaded in the lookup state once the result slot is free.
// Requests: a new request waits until the previous result is loaded; the
//   directory read is followed by the update and write-back of the same entry.
// Reset: counters and lease holder clear at once; the directory then runs a
//   clearing pass over every page with in_ready low before any request.
module page_ownership_directory_unit #(
    parameter int NODE_COUNT = 4,
    parameter int PAGE_COUNT = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  requester,
    input  logic [3:0]  page,
    input  logic [1:0]  mode,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [1:0]  previous_owner,
    output logic [3:0]  invalidate_mask,
    output logic [3:0]  readers_prior,
    output logic [31:0] page_transfer_count,
    output logic [31:0] lease_transfer_count,
    output logic [31:0] invalidation_count
);

    localparam int AW    = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int OWN_W = $clog2(NODE_COUNT);
    localparam int CNT_W = $clog2(NODE_COUNT + 1);

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t                state_reg;
    logic                  out_valid_reg;
    logic [1:0]            req_reg;
    logic [3:0]            page_reg;
    pod_pkg::mode_t        mode_reg;
    logic [OWN_W-1:0]      lease_holder_reg;
    logic [31:0]           page_cnt_reg;
    logic [31:0]           lease_cnt_reg;
    logic [31:0]           inv_cnt_reg;
    logic [1:0]            status_reg;
    logic [1:0]            prev_owner_reg;
    logic [3:0]            inv_mask_reg;
    logic [3:0]            readers_prior_reg;

    logic                  mem_busy;
    logic                  accept;
    logic                  result_load;
    logic [AW+3:0]         page_wide;
    logic [AW+3:0]         page_reg_wide;
    logic [OWN_W+1:0]      req_reg_wide;
    logic [OWN_W-1:0]      rd_owner;
    logic [NODE_COUNT-1:0] rd_readers;
    logic                  mem_we;

    pod_pkg::pod_decision_t decision;
    logic [1:0]            upd_status;
    logic [1:0]            upd_prev_owner;
    logic [3:0]            upd_inv_mask;
    logic [3:0]            upd_readers_prior;
    logic [OWN_W-1:0]      upd_owner;
    logic [NODE_COUNT-1:0] upd_readers;
    logic [CNT_W-1:0]      upd_inv_count;

    // Handshake: take a request when idle and not clearing, load a result when the slot frees
    assign in_ready    = (state_reg == ST_IDLE) && !mem_busy;
    assign accept      = in_valid && in_ready;
    assign result_load = (state_reg == ST_LOOKUP) && (!out_valid_reg || out_ready);
    assign mem_we      = result_load && decision.page_grant;

    // Fit the page number to the directory address, the requester to a node
    assign page_wide     = {{AW{1'b0}}, page};
    assign page_reg_wide = {{AW{1'b0}}, page_reg};
    assign req_reg_wide  = {{OWN_W{1'b0}}, req_reg};

    pod_dir_mem #(
        .PAGE_COUNT (PAGE_COUNT),
        .NODE_COUNT (NODE_COUNT),
        .AW         (AW),
        .OWN_W      (OWN_W)
    ) u_dir_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .re         (accept),
        .raddr      (page_wide[AW-1:0]),
        .rd_owner   (rd_owner),
        .rd_readers (rd_readers),
        .we         (mem_we),
        .waddr      (page_reg_wide[AW-1:0]),
        .wr_owner   (upd_owner),
        .wr_readers (upd_readers),
        .busy       (mem_busy)
    );

    pod_update #(
        .PAGE_COUNT (PAGE_COUNT),
        .NODE_COUNT (NODE_COUNT),
        .OWN_W      (OWN_W),
        .CNT_W      (CNT_W)
    ) u_update (
        .requester       (req_reg),
        .page            (page_reg),
        .mode            (mode_reg),
        .entry_owner     (rd_owner),
        .entry_readers   (rd_readers),
        .lease_holder    (lease_holder_reg),
        .decision        (decision),
        .status          (upd_status),
        .previous_owner  (upd_prev_owner),
        .invalidate_mask (upd_inv_mask),
        .readers_prior   (upd_readers_prior),
        .new_owner       (upd_owner),
        .new_readers     (upd_readers),
        .inv_count       (upd_inv_count)
    );

    // Hold state, request, counters and the result slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            out_valid_reg      <= 1'b0;
            req_reg            <= '0;
            page_reg           <= '0;
            mode_reg           <= pod_pkg::REQ_SHARE;
            lease_holder_reg   <= '0;
            page_cnt_reg       <= '0;
            lease_cnt_reg      <= '0;
            inv_cnt_reg        <= '0;
            status_reg         <= pod_pkg::STATUS_GRANTED;
            prev_owner_reg     <= '0;
            inv_mask_reg       <= '0;
            readers_prior_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready && !result_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        req_reg   <= requester;
                        page_reg  <= page;
                        mode_reg  <= pod_pkg::mode_t'(mode);
                        state_reg <= ST_LOOKUP;
                    end
                end
                ST_LOOKUP:
                begin
                    if (result_load)
                    begin
                        if (decision.lease_grant)
                        begin
                            lease_holder_reg <= req_reg_wide[OWN_W-1:0];
                        end
                        page_cnt_reg  <= page_cnt_reg + 32'(decision.page_grant);
                        lease_cnt_reg <= lease_cnt_reg + 32'(decision.lease_grant);
                        inv_cnt_reg   <= inv_cnt_reg + 32'(upd_inv_count);
                        status_reg         <= upd_status;
                        prev_owner_reg     <= upd_prev_owner;
                        inv_mask_reg       <= upd_inv_mask;
                        readers_prior_reg  <= upd_readers_prior;
                        out_valid_reg      <= 1'b1;
                        state_reg          <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid            = out_valid_reg;
    assign status               = status_reg;
    assign previous_owner       = prev_owner_reg;
    assign invalidate_mask      = inv_mask_reg;
    assign readers_prior        = readers_prior_reg;
    assign page_transfer_count  = page_cnt_reg;
    assign lease_transfer_count = lease_cnt_reg;
    assign invalidation_count   = inv_cnt_reg;

`ifndef NO_ASSERTIONS
    // No request is taken while the directory is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        mem_busy |-> !in_ready)
        else $error("request accepted during directory clearing");

    // An accepted request is always followed by its lookup cycle
    a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOOKUP)
        else $error("accepted request did not enter lookup");

    // Counters move only when a result is loaded
    a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !result_load |=> $stable(page_cnt_reg) && $stable(lease_cnt_reg)
                         && $stable(inv_cnt_reg))
        else $error("counter changed without a result");

    // Invalidations only accompany a granted request
    a_inv_only_granted: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (inv_mask_reg == 4'b0000
                           || status_reg == pod_pkg::STATUS_GRANTED))
        else $error("invalidate mask on a refused request");
`endif

endmodule : page_ownership_directory_unit

[rtl/pod_dir_mem.sv]
// ----------------------------------------------------------------------------
// pod_dir_mem
// Directory storage: one owner and one reader mask per page, single write
// port, one read port with registered data. Runs a clearing pass after reset
// that loads each page with its home node and an empty reader mask.
// ----------------------------------------------------------------------------
module pod_dir_mem #(
    parameter int PAGE_COUNT = 16,
    parameter int NODE_COUNT = 4,
    parameter int AW         = 4,
    parameter int OWN_W      = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  re,
    input  logic [AW-1:0]         raddr,
    output logic [OWN_W-1:0]      rd_owner,
    output logic [NODE_COUNT-1:0] rd_readers,
    input  logic                  we,
    input  logic [AW-1:0]         waddr,
    input  logic [OWN_W-1:0]      wr_owner,
    input  logic [NODE_COUNT-1:0] wr_readers,
    output logic                  busy
);

    logic [OWN_W-1:0]      owner_mem   [PAGE_COUNT];
    logic [NODE_COUNT-1:0] readers_mem [PAGE_COUNT];

    logic                  clear_busy_reg;
    logic [AW-1:0]         clr_idx_reg;
    logic [OWN_W-1:0]      clr_node_reg;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [OWN_W-1:0]      mem_owner;
    logic [NODE_COUNT-1:0] mem_readers;

    // Sweep every page once after reset; home node wraps at the node count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_busy_reg <= 1'b1;
            clr_idx_reg    <= '0;
            clr_node_reg   <= '0;
        end
        else if (clear_busy_reg)
        begin
            if (clr_idx_reg == AW'(PAGE_COUNT - 1))
            begin
                clear_busy_reg <= 1'b0;
            end
            clr_idx_reg <= clr_idx_reg + AW'(1);
            if (clr_node_reg == OWN_W'(NODE_COUNT - 1))
            begin
                clr_node_reg <= '0;
            end
            else
            begin
                clr_node_reg <= clr_node_reg + OWN_W'(1);
            end
        end
    end

    // Select between the clearing sweep and normal updates
    always_comb
    begin
        if (clear_busy_reg)
        begin
            mem_we      = 1'b1;
            mem_waddr   = clr_idx_reg;
            mem_owner   = clr_node_reg;
            mem_readers = '0;
        end
        else
        begin
            mem_we      = we;
            mem_waddr   = waddr;
            mem_owner   = wr_owner;
            mem_readers = wr_readers;
        end
    end

    // Storage array with registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            owner_mem[mem_waddr]   <= mem_owner;
            readers_mem[mem_waddr] <= mem_readers;
        end
        if (re)
        begin
            rd_owner   <= owner_mem[raddr];
            rd_readers <= readers_mem[raddr];
        end
    end

    assign busy = clear_busy_reg;

endmodule : pod_dir_mem

[rtl/pod_update.sv]
// ----------------------------------------------------------------------------
// pod_update
// Request decision logic: classifies a request against the fetched page
// entry or the lease holder and forms the result fields, the new page entry
// and the number of invalidations sent.
// ----------------------------------------------------------------------------
module pod_update #(
    parameter int PAGE_COUNT = 16,
    parameter int NODE_COUNT = 4,
    parameter int OWN_W      = 2,
    parameter int CNT_W      = 3
) (
    input  logic [1:0]            requester,
    input  logic [3:0]            page,
    input  pod_pkg::mode_t        mode,
    input  logic [OWN_W-1:0]      entry_owner,
    input  logic [NODE_COUNT-1:0] entry_readers,
    input  logic [OWN_W-1:0]      lease_holder,
    output pod_pkg::pod_decision_t decision,
    output logic [1:0]            status,
    output logic [1:0]            previous_owner,
    output logic [3:0]            invalidate_mask,
    output logic [3:0]            readers_prior,
    output logic [OWN_W-1:0]      new_owner,
    output logic [NODE_COUNT-1:0] new_readers,
    output logic [CNT_W-1:0]      inv_count
);

    logic                  req_ok;
    logic                  page_ok;
    logic [OWN_W+1:0]      req_wide;
    logic [OWN_W-1:0]      req_own;
    logic [NODE_COUNT-1:0] req_bit;
    logic [NODE_COUNT-1:0] inv_vec;
    logic [OWN_W-1:0]      prev_own;
    logic [NODE_COUNT-1:0] before_vec;
    logic [OWN_W+1:0]      prev_wide;
    logic [NODE_COUNT+3:0] before_wide;
    logic [NODE_COUNT+3:0] inv_wide;

    // Range checks and requester decode
    assign req_ok   = int'(requester) < NODE_COUNT;
    assign page_ok  = int'(page) < PAGE_COUNT;
    assign req_wide = {{OWN_W{1'b0}}, requester};
    assign req_own  = req_wide[OWN_W-1:0];

    always_comb
    begin
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            req_bit[i] = (req_own == OWN_W'(i));
        end
    end

    // Classify the request and form the new entry
    always_comb
    begin
        decision    = '0;
        status      = pod_pkg::STATUS_GRANTED;
        prev_own    = '0;
        before_vec  = '0;
        inv_vec     = '0;
        new_owner   = entry_owner;
        new_readers = entry_readers;
        if (mode == pod_pkg::REQ_ILLEGAL || !req_ok)
        begin
            decision.bad = 1'b1;
            status       = pod_pkg::STATUS_BAD;
        end
        else if (mode == pod_pkg::REQ_LEASE)
        begin
            prev_own = lease_holder;
            if (lease_holder == req_own)
            begin
                decision.already = 1'b1;
                status           = pod_pkg::STATUS_OWNER;
            end
            else
            begin
                decision.lease_grant = 1'b1;
            end
        end
        else if (!page_ok)
        begin
            decision.bad = 1'b1;
            status       = pod_pkg::STATUS_BAD;
        end
        else
        begin
            prev_own   = entry_owner;
            before_vec = entry_readers;
            if (entry_owner == req_own)
            begin
                decision.already = 1'b1;
                status           = pod_pkg::STATUS_OWNER;
            end
            else if (mode == pod_pkg::REQ_SHARE)
            begin
                decision.page_grant = 1'b1;
                new_readers         = entry_readers | req_bit;
            end
            else
            begin
                decision.page_grant  = 1'b1;
                decision.write_grant = 1'b1;
                inv_vec              = entry_readers & ~req_bit;
                new_owner            = req_own;
                new_readers          = '0;
            end
        end
    end

    // Count invalidation targets
    always_comb
    begin
        inv_count = '0;
        for (int i = 0; i < NODE_COUNT; i++)
        begin
            inv_count = inv_count + CNT_W'(inv_vec[i]);
        end
    end

    // Fit internal widths to the result fields
    assign prev_wide       = {2'b00, prev_own};
    assign before_wide     = {4'b0000, before_vec};
    assign inv_wide        = {4'b0000, inv_vec};
    assign previous_owner  = prev_wide[1:0];
    assign readers_prior   = before_wide[3:0];
    assign invalidate_mask = inv_wide[3:0];

endmodule : pod_update

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for page_ownership_directory_unit. Directed, then random
// read, write, lease and malformed requests go in, one at a time, over a
// valid/ready channel. A scoreboard keeps its own copy of the directory
// (owners, reader masks, lease holder, counters) and predicts every result.
// Both channels idle at random. The output side also holds off for a long
// stretch so that the input stalls, and the input drains fully now and then.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES         = 4;
    localparam int PAGES         = 16;
    localparam int RANDOM_ITEMS  = 1250;
    localparam int IDLE_LIMIT    = 2000;
    localparam int LONG_HOLD     = 60;
    localparam int LONG_HOLD_AT  = 600;
    localparam int TAIL_CYCLES   = 8;

    // One predicted or observed result
    typedef struct packed {
        logic [1:0]  status;
        logic [1:0]  prev_owner;
        logic [3:0]  inval_mask;
        logic [3:0]  readers;
        logic [31:0] page_moves;
        logic [31:0] lease_moves;
        logic [31:0] invals;
    } directory_result_t;

    // ------------------------------------------------------------------------
    // Directory scoreboard: shadow directory state and pending results
    // ------------------------------------------------------------------------
    class directory_scoreboard;
        logic [1:0]        owner_of   [PAGES];
        logic [3:0]        readers_of [PAGES];
        logic [1:0]        lease_node;
        logic [31:0]       page_moves;
        logic [31:0]       lease_moves;
        logic [31:0]       invals_sent;
        directory_result_t pending_q [$];
        int unsigned       mismatches;

        function new();
            for (int p = 0; p < PAGES; p++)
            begin
                owner_of[p]   = 2'(p % NODES);
                readers_of[p] = '0;
            end
            lease_node  = '0;
            page_moves  = '0;
            lease_moves = '0;
            invals_sent = '0;
            mismatches  = 0;
        endfunction

        function int pending();
            return pending_q.size();
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endtask

        // Apply one accepted request to the shadow directory
        function void note_request(logic [1:0] rq, logic [3:0] pg, logic [1:0] md);
            directory_result_t r;
            logic [3:0]        node_bit;
            logic [3:0]        node_mask;
            r         = '0;
            r.status  = pod_pkg::STATUS_GRANTED;
            node_bit  = 4'(1) << rq;
            node_mask = 4'((1 << NODES) - 1);
            if (md == pod_pkg::REQ_ILLEGAL || int'(rq) >= NODES)
            begin
                r.status = pod_pkg::STATUS_BAD;
            end
            else if (md == pod_pkg::REQ_LEASE)
            begin
                r.prev_owner = lease_node;
                if (lease_node == rq)
                    r.status = pod_pkg::STATUS_OWNER;
                else
                begin
                    lease_node  = rq;
                    lease_moves = lease_moves + 32'd1;
                end
            end
            else if (int'(pg) >= PAGES)
            begin
                r.status = pod_pkg::STATUS_BAD;
            end
            else
            begin
                r.prev_owner = owner_of[pg];
                r.readers    = readers_of[pg];
                if (owner_of[pg] == rq)
                    r.status = pod_pkg::STATUS_OWNER;
                else if (md == pod_pkg::REQ_SHARE)
                begin
                    readers_of[pg] = (readers_of[pg] | node_bit) & node_mask;
                    page_moves     = page_moves + 32'd1;
                end
                else
                begin
                    // invalidate every other reader, hand ownership over
                    r.inval_mask   = r.readers & ~node_bit & node_mask;
                    invals_sent    = invals_sent + 32'($countones(r.inval_mask));
                    owner_of[pg]   = rq;
                    readers_of[pg] = '0;
                    page_moves     = page_moves + 32'd1;
                end
            end
            r.page_moves  = page_moves;
            r.lease_moves = lease_moves;
            r.invals      = invals_sent;
            pending_q.push_back(r);
        endfunction

        // Compare one accepted result with the oldest prediction
        task check_result(directory_result_t got);
            directory_result_t want;
            if (pending_q.size() == 0)
            begin
                report_mismatch("result with no request waiting");
                return;
            end
            want = pending_q.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d",
                                          got.status, want.status));
            if (got.prev_owner !== want.prev_owner)
                report_mismatch($sformatf("previous_owner got %0d want %0d",
                                          got.prev_owner, want.prev_owner));
            if (got.inval_mask !== want.inval_mask)
                report_mismatch($sformatf("invalidate_mask got %h want %h",
                                          got.inval_mask, want.inval_mask));
            if (got.readers !== want.readers)
                report_mismatch($sformatf("readers_prior got %h want %h",
                                          got.readers, want.readers));
            if (got.page_moves !== want.page_moves)
                report_mismatch($sformatf("page_transfer_count got %0d want %0d",
                                          got.page_moves, want.page_moves));
            if (got.lease_moves !== want.lease_moves)
                report_mismatch($sformatf("lease_transfer_count got %0d want %0d",
                                          got.lease_moves, want.lease_moves));
            if (got.invals !== want.invals)
                report_mismatch($sformatf("invalidation_count got %0d want %0d",
                                          got.invals, want.invals));
        endtask
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  requester;
    logic [3:0]  page;
    logic [1:0]  mode;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  status;
    logic [1:0]  previous_owner;
    logic [3:0]  invalidate_mask;
    logic [3:0]  readers_prior;
    logic [31:0] page_transfer_count;
    logic [31:0] lease_transfer_count;
    logic [31:0] invalidation_count;

    directory_scoreboard sb = new();

    bit          sender_calm;
    int unsigned results_seen;
    int unsigned idle_cycles = 0;

    page_ownership_directory_unit #(
        .NODE_COUNT (NODES),
        .PAGE_COUNT (PAGES)
    ) dut (
        .clk                  (clk),
        .rst_n                (rst_n),
        .in_valid             (in_valid),
        .in_ready             (in_ready),
        .requester            (requester),
        .page                 (page),
        .mode                 (mode),
        .out_valid            (out_valid),
        .out_ready            (out_ready),
        .status               (status),
        .previous_owner       (previous_owner),
        .invalidate_mask      (invalidate_mask),
        .readers_prior        (readers_prior),
        .page_transfer_count  (page_transfer_count),
        .lease_transfer_count (lease_transfer_count),
        .invalidation_count   (invalidation_count)
    );

    // Clock: 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Sample both channels on the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_request(requester, page, mode);
            if (out_valid && out_ready)
                sb.check_result({status, previous_owner, invalidate_mask,
                                 readers_prior, page_transfer_count,
                                 lease_transfer_count, invalidation_count});
        end
    end

    // Watchdog: end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("page_ownership_directory_unit verification failed");
            $finish;
        end
    end

    // Offer one request after a random gap (none while calm), hold it until accepted
    task send_request(input logic [1:0] rq, input logic [3:0] pg,
                      input pod_pkg::mode_t md);
        int unsigned gap;
        gap = sender_calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        requester <= rq;
        page      <= pg;
        mode      <= md;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stop offering until every predicted result has arrived
    task drain_results();
        in_valid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // Result side: random stalls, calm bands and one long hold-off
    initial
    begin
        int unsigned gap;
        out_ready    <= 1'b0;
        results_seen = 0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (results_seen == LONG_HOLD_AT)
                gap = LONG_HOLD;
            else if ((results_seen / 150) % 4 == 2)
                gap = 0;
            else
                gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            results_seen++;
        end
    end

    // Reset, directed requests, random requests, final verdict
    initial
    begin
        logic [1:0]     rq;
        logic [3:0]     pg;
        logic [3:0]     hot_page;
        pod_pkg::mode_t md;
        int unsigned    pick;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        requester   <= '0;
        page        <= '0;
        mode        <= pod_pkg::REQ_SHARE;
        sender_calm = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // build up readers on page 0, then already-owner read and invalidating write
        send_request(2'd1, 4'd0, pod_pkg::REQ_SHARE);
        send_request(2'd2, 4'd0, pod_pkg::REQ_SHARE);
        send_request(2'd3, 4'd0, pod_pkg::REQ_SHARE);
        send_request(2'd0, 4'd0, pod_pkg::REQ_SHARE);
        send_request(2'd1, 4'd0, pod_pkg::REQ_OWN);
        send_request(2'd1, 4'd0, pod_pkg::REQ_OWN);
        // top page: owner refusal, own-read then write with nothing to invalidate
        send_request(2'd3, 4'd15, pod_pkg::REQ_SHARE);
        send_request(2'd0, 4'd15, pod_pkg::REQ_SHARE);
        send_request(2'd0, 4'd15, pod_pkg::REQ_OWN);
        // lease held, lease moved, page field ignored
        send_request(2'd0, 4'd0, pod_pkg::REQ_LEASE);
        send_request(2'd3, 4'd15, pod_pkg::REQ_LEASE);
        send_request(2'd3, 4'd0, pod_pkg::REQ_LEASE);
        send_request(2'd1, 4'd9, pod_pkg::REQ_LEASE);
        // malformed mode at both field extremes
        send_request(2'd3, 4'd15, pod_pkg::REQ_ILLEGAL);
        send_request(2'd0, 4'd0, pod_pkg::REQ_ILLEGAL);
        // three readers on page 10, owner write refused, foreign write invalidates
        send_request(2'd2, 4'd10, pod_pkg::REQ_SHARE);
        send_request(2'd0, 4'd10, pod_pkg::REQ_SHARE);
        send_request(2'd1, 4'd10, pod_pkg::REQ_SHARE);
        send_request(2'd3, 4'd10, pod_pkg::REQ_SHARE);
        send_request(2'd2, 4'd10, pod_pkg::REQ_OWN);
        send_request(2'd0, 4'd10, pod_pkg::REQ_OWN);
        // plain write with no readers, repeated read by the same node
        send_request(2'd2, 4'd5, pod_pkg::REQ_OWN);
        send_request(2'd3, 4'd6, pod_pkg::REQ_SHARE);
        send_request(2'd3, 4'd6, pod_pkg::REQ_SHARE);
        drain_results();

        // random traffic focused on a few hot pages to grow reader sets
        hot_page = 4'($urandom_range(0, 14));
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 50 == 0)
                hot_page = 4'($urandom_range(0, 14));
            sender_calm = ((i / 125) % 3 == 1) || (i >= 520 && i < 700);
            if (i == 350 || i == 900)
                drain_results();
            pick = $urandom_range(0, 99);
            if (pick < 45)
                md = pod_pkg::REQ_SHARE;
            else if (pick < 83)
                md = pod_pkg::REQ_OWN;
            else if (pick < 95)
                md = pod_pkg::REQ_LEASE;
            else
                md = pod_pkg::REQ_ILLEGAL;
            rq = 2'($urandom_range(0, 3));
            if ($urandom_range(0, 3) != 0)
                pg = hot_page + 4'($urandom_range(0, 1));
            else
                pg = 4'($urandom_range(0, 15));
            send_request(rq, pg, md);
        end
        in_valid <= 1'b0;

        // wait for the last results and a short tail
        @(negedge clk);
        while (sb.pending() != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d predicted results never arrived",
                                         sb.pending()));
        if (sb.mismatches == 0)
            $display("page_ownership_directory_unit verification clean");
        else
            $display("page_ownership_directory_unit verification failed");
        $finish;
    end

endmodule : tb_top

[sim.f]
rtl/pod_pkg.sv
rtl/pod_dir_mem.sv
rtl/pod_update.sv
rtl/page_ownership_directory_unit.sv
tb/tb_top.sv
